/* hdl/ale_pkg.sv */
package ale_pkg;

   // Default number of list slots.
   localparam int DEPTH_DEF = 64;

   // Field widths.
   localparam int ELEM_W = 32;
   localparam int IDX_W  = 7;
   localparam int CAP_W  = 7;
   localparam int OP_W   = 4;
   localparam int ST_W   = 2;

   // Channel widths; the tdata widths are padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = OP_W;
   localparam int RSP_TDATA_W = ELEM_W;
   localparam int RSP_TUSER_W = ST_W;
   localparam int CSR_TDATA_W = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      REQ_APPEND  = 4'd0,
      REQ_INSERT  = 4'd1,
      REQ_DELETE  = 4'd2,
      REQ_SEARCH  = 4'd3,
      REQ_GET     = 4'd4,
      REQ_SET     = 4'd5,
      REQ_MAX     = 4'd6,
      REQ_MIN     = 4'd7,
      REQ_SUM     = 4'd8,
      REQ_AVERAGE = 4'd9
   } req_code_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADIDX   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_DIV,
      S_DONE
   } state_type;

endpackage

/* hdl/array_list_engine.sv */
// Channel  Direction  Payload (lowest bits first)               Handshake
// req      in         tuser: req_type[3:0]                      req_tvalid / req_tready
//                     tdata: index[6:0], element[38:7], pad
// rsp      out        tuser: status[1:0]; tdata: value[31:0]    rsp_tvalid / rsp_tready
// csr      in         tdata: capacity[6:0], pad                 csr_tvalid / csr_tready
//
// One request is worked on at a time; req_tready is high only while the sequencer is idle.
// A request that walks stored elements (shifts, search, max, min, sum, get) reads them one by
// one; insert and a search hit that swaps add a separate write step afterwards, as the element
// memory has one read and one write port. Average then runs the serial divider, one quotient
// bit per cycle. Append and set write their slot without a walk, and a rejected request goes
// straight on to its response. Reset clears the count and the control state only; the element
// memory is never cleared, as only written slots are ever read. A waiting result sits in the
// output register while the next request is taken; a stalled result only holds back the finish
// of the following request.
module array_list_engine #(
   parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // index [6:0], element [38:7], zero pad [39]
   input  logic [ale_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type [3:0]
   input  logic [ale_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value [31:0]
   output logic [ale_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [ale_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            csr_tvalid,
   output logic                            csr_tready,
   // capacity [6:0], zero pad [7]
   input  logic [ale_pkg::CSR_TDATA_W-1:0] csr_tdata
);
   import ale_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMPW  = (CW > IDX_W) ? CW : IDX_W;
   localparam int SUM_W = ELEM_W + CW;
   localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

   // Sequencer and request registers.
   state_type               state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [ELEM_W-1:0]       key_ff, key_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;

   // Scan walker: issues one memory read per cycle from ptr_ff towards last_ff.
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [AW-1:0]           last_ff, last_in;
   logic                    down_ff, down_in;
   logic                    issue_ff, issue_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic [ELEM_W-1:0]       rd_data_ff;
   logic [ELEM_W-1:0]       prev_ff, prev_in;
   logic [AW-1:0]           wr_addr_ff, wr_addr_in;

   // Result being built and the output register.
   logic signed [SUM_W-1:0] acc_ff, acc_in, acc_sum;
   logic [ELEM_W-1:0]       val_ff, val_in;
   status_type              st_ff, st_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]  rsp_user_ff, rsp_user_in;

   // Element memory.
   logic [ELEM_W-1:0]       mem_q [DEPTH];
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [ELEM_W-1:0]       mem_wd;

   // Request decode.
   logic [OP_W-1:0]         req_op;
   logic [IDX_W-1:0]        req_idx;
   logic [ELEM_W-1:0]       req_elem;
   logic [CMPW-1:0]         n_c, i_c, cap_c, cap_eff;
   logic [AW-1:0]           n_a, nm1_a, idx_a;
   state_type               dsp_state;
   status_type              dsp_st;
   logic [AW-1:0]           dsp_first, dsp_last, dsp_waddr;

   logic                    rd_last, hit;
   logic                    div_start, div_done;
   logic [ELEM_W-1:0]       div_quo;

   assign req_op   = req_tuser[OP_W-1:0];
   assign req_idx  = req_tdata[IDX_W-1:0];
   assign req_elem = req_tdata[IDX_W +: ELEM_W];

   // The capacity register is saturated into the range one to DEPTH.
   assign n_c     = CMPW'(count_ff);
   assign i_c     = CMPW'(req_idx);
   assign cap_c   = CMPW'(cap_ff);
   assign cap_eff = (cap_ff == '0) ? CMPW'(1) : ((cap_c > DEPTH_C) ? DEPTH_C : cap_c);
   assign n_a     = count_ff[AW-1:0];
   assign nm1_a   = AW'(count_ff - 1'b1);
   assign idx_a   = i_c[AW-1:0];

   // Dispatch: error checks and the plan for the walk, decided as the request is taken.
   always_comb begin
      dsp_state = S_DONE;
      dsp_st    = ST_OK;
      dsp_first = '0;
      dsp_last  = nm1_a;
      dsp_waddr = idx_a;
      case (req_op)
         REQ_APPEND: begin
            dsp_waddr = n_a;
            if (n_c >= cap_eff) begin
               dsp_st = ST_FULL;
            end else begin
               dsp_state = S_TAIL;
            end
         end
         REQ_INSERT: begin
            if (i_c > n_c) begin
               dsp_st = ST_BADIDX;
            end else if (n_c >= cap_eff) begin
               dsp_st = ST_FULL;
            end else if (i_c == n_c) begin
               dsp_state = S_TAIL;
            end else begin
               // Shift upwards, starting from the top element.
               dsp_state = S_SCAN;
               dsp_first = nm1_a;
               dsp_last  = idx_a;
            end
         end
         REQ_DELETE: begin
            if (i_c >= n_c) begin
               dsp_st = ST_BADIDX;
            end else begin
               dsp_state = S_SCAN;
               dsp_first = idx_a;
            end
         end
         REQ_SEARCH: begin
            dsp_st    = ST_NOTFOUND;
            dsp_waddr = '0;
            if (n_c != '0) begin
               dsp_state = S_SCAN;
            end
         end
         REQ_GET: begin
            if (i_c >= n_c) begin
               dsp_st = ST_BADIDX;
            end else begin
               dsp_state = S_SCAN;
               dsp_first = idx_a;
               dsp_last  = idx_a;
            end
         end
         REQ_SET: begin
            if (i_c >= n_c) begin
               dsp_st = ST_BADIDX;
            end else begin
               dsp_state = S_TAIL;
            end
         end
         REQ_MAX, REQ_MIN, REQ_AVERAGE: begin
            if (n_c == '0) begin
               dsp_st = ST_BADIDX;
            end else begin
               dsp_state = S_SCAN;
            end
         end
         REQ_SUM: begin
            // An empty list sums to zero without complaint.
            if (n_c != '0) begin
               dsp_state = S_SCAN;
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_last = rd_addr_ff == last_ff;
   assign hit     = rd_data_ff == key_ff;
   assign acc_sum = acc_ff + SUM_W'($signed(rd_data_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = dsp_state;
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               case (op_ff)
                  REQ_SEARCH: begin
                     if (hit) begin
                        state_in = (rd_addr_ff != '0) ? S_TAIL : S_DONE;
                     end else if (rd_last) begin
                        state_in = S_DONE;
                     end
                  end
                  REQ_INSERT: begin
                     if (rd_last) begin
                        state_in = S_TAIL;
                     end
                  end
                  REQ_AVERAGE: begin
                     if (rd_last) begin
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     if (rd_last) begin
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_TAIL: begin
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      cap_in      = cap_ff;
      ptr_in      = ptr_ff;
      last_in     = last_ff;
      down_in     = down_ff;
      issue_in    = issue_ff;
      prev_in     = prev_ff;
      wr_addr_in  = wr_addr_ff;
      acc_in      = acc_ff;
      val_in      = val_ff;
      st_in       = st_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      mem_we      = 1'b0;
      mem_wa      = rd_addr_ff;
      mem_wd      = rd_data_ff;
      div_start   = 1'b0;

      // The read data for the address issued now comes back in the next cycle.
      rd_vld_in  = (state_ff == S_SCAN) && issue_ff;
      rd_addr_in = ptr_ff;
      if ((state_ff == S_SCAN) && issue_ff) begin
         if (ptr_ff == last_ff) begin
            issue_in = 1'b0;
         end else begin
            ptr_in = down_ff ? AW'(ptr_ff - 1'b1) : AW'(ptr_ff + 1'b1);
         end
      end

      if (csr_tvalid) begin
         cap_in = csr_tdata[CAP_W-1:0];
      end

      if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_op;
               key_in     = req_elem;
               val_in     = '0;
               st_in      = dsp_st;
               acc_in     = '0;
               ptr_in     = dsp_first;
               last_in    = dsp_last;
               down_in    = req_op == REQ_INSERT;
               issue_in   = dsp_state == S_SCAN;
               wr_addr_in = dsp_waddr;
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               case (op_ff)
                  REQ_INSERT: begin
                     mem_we = 1'b1;
                     mem_wa = AW'(rd_addr_ff + 1'b1);
                  end
                  REQ_DELETE: begin
                     // The first element read is the one removed; the rest move down.
                     if (rd_addr_ff == wr_addr_ff) begin
                        val_in = rd_data_ff;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = AW'(rd_addr_ff - 1'b1);
                     end
                     if (rd_last) begin
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  REQ_SEARCH: begin
                     prev_in = rd_data_ff;
                     if (hit) begin
                        val_in     = ELEM_W'(rd_addr_ff);
                        st_in      = ST_OK;
                        wr_addr_in = AW'(rd_addr_ff - 1'b1);
                        // Move the predecessor up now; the key goes below it next cycle.
                        if (rd_addr_ff != '0) begin
                           mem_we = 1'b1;
                           mem_wa = rd_addr_ff;
                           mem_wd = prev_ff;
                        end
                     end
                  end
                  REQ_GET: begin
                     val_in = rd_data_ff;
                  end
                  REQ_MAX: begin
                     if ((rd_addr_ff == '0) || ($signed(rd_data_ff) > $signed(val_ff))) begin
                        val_in = rd_data_ff;
                     end
                  end
                  REQ_MIN: begin
                     if ((rd_addr_ff == '0) || ($signed(rd_data_ff) < $signed(val_ff))) begin
                        val_in = rd_data_ff;
                     end
                  end
                  REQ_SUM: begin
                     acc_in = acc_sum;
                     if (rd_last) begin
                        val_in = acc_sum[ELEM_W-1:0];
                     end
                  end
                  REQ_AVERAGE: begin
                     acc_in = acc_sum;
                     if (rd_last) begin
                        div_start = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TAIL: begin
            mem_we = 1'b1;
            mem_wa = wr_addr_ff;
            mem_wd = key_ff;
            if (op_ff inside {REQ_APPEND, REQ_INSERT}) begin
               count_in = CW'(count_ff + 1'b1);
            end
         end
         S_DIV: begin
            if (div_done) begin
               val_in = div_quo;
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = val_ff;
               rsp_user_in = st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cap_ff     <= CAP_RESET;
         issue_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cap_ff     <= cap_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      ptr_ff      <= ptr_in;
      last_ff     <= last_in;
      down_ff     <= down_in;
      rd_addr_ff  <= rd_addr_in;
      prev_ff     <= prev_in;
      wr_addr_ff  <= wr_addr_in;
      acc_ff      <= acc_in;
      val_ff      <= val_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem_q[ptr_ff];
   end

   ale_div #(
      .NUM_W (SUM_W),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_sum),
      .den   (count_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_tready = 1'b1;

endmodule

/* hdl/ale_div.sv */
module ale_div #(
   parameter int NUM_W = 39,
   parameter int DEN_W = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic                       done,
   output logic [ale_pkg::ELEM_W-1:0] quo
);
   import ale_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Restoring division of the magnitude, one quotient bit per cycle.
   assign trial = {rem_ff, mag_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[NUM_W-1];
         mag_in  = num[NUM_W-1] ? NUM_W'(~num + 1'b1) : num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         mag_in = {mag_ff[NUM_W-2:0], ge};
         cnt_in = CNT_W'(cnt_ff - 1'b1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? ELEM_W'(~mag_ff[ELEM_W-1:0] + 1'b1) : mag_ff[ELEM_W-1:0];

endmodule

/* tb/sv/array_list_checker.sv */
`timescale 1ns / 1ps

module array_list_checker #(
   parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ale_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [ale_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ale_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [ale_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            csr_tvalid,
   input  logic                            csr_tready,
   input  logic [ale_pkg::CSR_TDATA_W-1:0] csr_tdata,
   output int                              error_count,
   output int                              answers_due
);
   import ale_pkg::*;

   // Past this many failures the remaining ones are counted but not printed.
   localparam int REPORT_LIMIT = 200;

   typedef struct packed {
      logic [OP_W-1:0]   code;
      logic [ELEM_W-1:0] value;
      status_type        status;
   } list_answer_type;

   logic signed [ELEM_W-1:0] slots [DEPTH];
   int                       slot_count = 0;
   int                       list_cap   = CAP_RESET;
   list_answer_type          answers_owed [$];
   int                       fails = 0;

   // Carries out one request on the local copy of the list and returns its answer.
   function automatic list_answer_type apply_request(input logic [OP_W-1:0] code, input int pos,
                                                     input logic signed [ELEM_W-1:0] item);
      list_answer_type          ans;
      int                       n;
      int                       cap;
      int                       k;
      bit                       hit;
      logic signed [ELEM_W-1:0] pick;
      logic signed [63:0]       total;
      ans.code   = code;
      ans.value  = '0;
      ans.status = ST_OK;
      n   = slot_count;
      cap = (list_cap < 1) ? 1 : ((list_cap > DEPTH) ? DEPTH : list_cap);
      case (code)
         REQ_APPEND: begin
            if (n >= cap) ans.status = ST_FULL;
            else begin
               slots[n]   = item;
               slot_count = n + 1;
            end
         end
         REQ_INSERT: begin
            // The index is judged before fullness.
            if (pos > n) ans.status = ST_BADIDX;
            else if (n >= cap) ans.status = ST_FULL;
            else begin
               for (k = n; k > pos; k--) slots[k] = slots[k-1];
               slots[pos] = item;
               slot_count = n + 1;
            end
         end
         REQ_DELETE: begin
            if (pos >= n) ans.status = ST_BADIDX;
            else begin
               ans.value = slots[pos];
               for (k = pos; k + 1 < n; k++) slots[k] = slots[k+1];
               slots[n-1] = '0;
               slot_count = n - 1;
            end
         end
         REQ_SEARCH: begin
            // A hit moves the element one place towards the front.
            ans.status = ST_NOTFOUND;
            hit = 1'b0;
            for (k = 0; k < n && !hit; k++) begin
               if (slots[k] == item) begin
                  hit        = 1'b1;
                  ans.value  = k;
                  ans.status = ST_OK;
                  if (k > 0) begin
                     pick       = slots[k];
                     slots[k]   = slots[k-1];
                     slots[k-1] = pick;
                  end
               end
            end
         end
         REQ_GET: begin
            if (pos >= n) ans.status = ST_BADIDX;
            else ans.value = slots[pos];
         end
         REQ_SET: begin
            if (pos >= n) ans.status = ST_BADIDX;
            else slots[pos] = item;
         end
         REQ_MAX, REQ_MIN: begin
            if (n == 0) ans.status = ST_BADIDX;
            else begin
               pick = slots[0];
               for (k = 1; k < n; k++) begin
                  if ((code == REQ_MAX) ? (slots[k] > pick) : (slots[k] < pick)) pick = slots[k];
               end
               ans.value = pick;
            end
         end
         REQ_SUM, REQ_AVERAGE: begin
            total = '0;
            for (k = 0; k < n; k++) total += slots[k];
            if (code == REQ_SUM) ans.value = total[ELEM_W-1:0];
            else if (n == 0) ans.status = ST_BADIDX;
            else ans.value = ELEM_W'(total / n);
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      list_answer_type want;
      if (reset) begin
         slot_count = 0;
         list_cap   = CAP_RESET;
         answers_owed.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_owed.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("%0t: unrequested response, expected none, actual value %0d status %0d",
                           $time, $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = answers_owed.pop_front();
               if (rsp_tdata !== want.value) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display("%0t: request %0d value, expected %0d, actual %0d",
                              $time, want.code, $signed(want.value), $signed(rsp_tdata));
               end
               if (rsp_tuser !== want.status) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display("%0t: request %0d status, expected %0d, actual %0d",
                              $time, want.code, want.status, rsp_tuser);
               end
            end
         end
         if (csr_tvalid && csr_tready) list_cap = csr_tdata[CAP_W-1:0];
         if (req_tvalid && req_tready)
            answers_owed.push_back(apply_request(req_tuser, req_tdata[IDX_W-1:0],
                                                 req_tdata[IDX_W +: ELEM_W]));
      end
      error_count <= fails;
      answers_due <= answers_owed.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ale_pkg::*;

   // Cycles without any accepted request, response or register write before the run is
   // declared hung. It is set far above what the slowest request (average over a full list)
   // needs with stalls on either side, so this is ample.
   localparam int STALL_LIMIT   = 3000;
   // Quiet time after the last response, to catch anything the block sends unasked.
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASE_ITEMS   = 200;
   localparam int PHASES        = 8;

   // Request codes the block does not define; they must answer zero with status ok.
   localparam logic [OP_W-1:0] REQ_UNUSED_LO = 4'd10;
   localparam logic [OP_W-1:0] REQ_UNUSED_HI = 4'd15;

   localparam logic [ELEM_W-1:0] ELEM_MAX  = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] ELEM_MIN  = 32'h8000_0000;
   localparam logic [ELEM_W-1:0] ELEM_NEG1 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [OP_W-1:0]   code;
      logic [IDX_W-1:0]  pos;
      logic [ELEM_W-1:0] item;
   } list_request_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_tvalid = 1'b0;
   logic                   csr_tready;
   logic [CSR_TDATA_W-1:0] csr_tdata  = '0;

   int               error_count;
   int               answers_due;
   list_request_type req_backlog [$];
   int               req_gap      = 0;
   int               rsp_stall    = 0;
   int               quiet_cycles = 0;
   // While set, neither side inserts idle cycles, giving back-to-back stretches.
   bit               pacing_off   = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   array_list_engine #(
      .DEPTH(DEPTH_DEF)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   // The checker watches all three channels, keeps its own copy of the list and compares
   // every response with what it predicted for the matching request.
   array_list_checker #(
      .DEPTH(DEPTH_DEF)
   ) list_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_tvalid  (csr_tvalid),
      .csr_tready  (csr_tready),
      .csr_tdata   (csr_tdata),
      .error_count (error_count),
      .answers_due (answers_due)
   );

   // Every request and every response draws its own number of idle cycles.
   function automatic int draw_gap();
      return pacing_off ? 0 : int'($urandom_range(0, 12));
   endfunction

   // Request side. The backlog is fed by the stimulus below; each request presented also
   // fixes how long the channel stays idle once it has been taken. tvalid is held high
   // straight into the next request when no gap follows, so it is never dropped and raised
   // in the same step.
   always @(posedge clock) begin : req_pacing
      list_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (req_backlog.size() > 0) begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.code;
            req_tdata  <= {1'b0, nxt.item, nxt.pos};
            req_gap    <= draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side. After each response is taken, tready drops for a drawn number of
   // cycles; between stalls it stays high whether or not a response is waiting.
   always @(posedge clock) begin : rsp_pacing
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = draw_gap();
         rsp_stall  <= stall;
         rsp_tready <= (stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Hang detection: any accepted transfer on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(input logic [OP_W-1:0] code, input int pos,
                                input logic [ELEM_W-1:0] item);
      list_request_type one;
      one.code = code;
      one.pos  = IDX_W'(pos);
      one.item = item;
      req_backlog.push_back(one);
   endtask

   // Only ever called with the block idle: after reset or once every response is in.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_tdata  <= CSR_TDATA_W'(cap);
      csr_tvalid <= 1'b1;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Holds the sender back until every queued request is taken and answered.
   task automatic wait_all_answered();
      while (req_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (answers_due != 0) @(posedge clock);
   endtask

   initial begin
      logic [CAP_W-1:0]  cap_plan [PHASES];
      logic [OP_W-1:0]   code;
      logic [IDX_W-1:0]  pos;
      logic [ELEM_W-1:0] item;
      int                r;
      int                phase;
      int                k;
      bit                filling;

      // Capacity per random phase: the reset value, tiny lists, both saturating
      // extremes (zero acts as one, anything over the depth acts as the depth) and
      // a couple of random settings.
      cap_plan[0] = 7'd64;
      cap_plan[1] = 7'd2;
      cap_plan[2] = 7'd127;
      cap_plan[3] = 7'd0;
      cap_plan[4] = CAP_W'($urandom_range(1, 64));
      cap_plan[5] = 7'd33;
      cap_plan[6] = 7'd1;
      cap_plan[7] = CAP_W'($urandom_range(0, 127));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from an empty list at full capacity.
      write_capacity(7'd64);
      // Everything that needs at least one element, tried on the empty list. Sum of an
      // empty list is zero with status ok; search reports not found.
      queue_request(REQ_MAX, 0, '0);
      queue_request(REQ_MIN, 0, '0);
      queue_request(REQ_AVERAGE, 0, '0);
      queue_request(REQ_SUM, 0, '0);
      queue_request(REQ_SEARCH, 0, '0);
      queue_request(REQ_DELETE, 0, '0);
      queue_request(REQ_GET, 0, '0);
      queue_request(REQ_SET, 0, ELEM_NEG1);
      queue_request(REQ_INSERT, 1, ELEM_MAX);
      // Fill with the extremes, then insert at the front and at the very end.
      queue_request(REQ_APPEND, 0, ELEM_MAX);
      queue_request(REQ_APPEND, 0, ELEM_MIN);
      queue_request(REQ_APPEND, 0, ELEM_NEG1);
      queue_request(REQ_APPEND, 0, '0);
      queue_request(REQ_INSERT, 0, 32'd5);
      queue_request(REQ_INSERT, 5, 32'h5555_5555);
      // Highest index on insert and get.
      queue_request(REQ_INSERT, 127, 32'd7);
      queue_request(REQ_GET, 127, '0);
      // Sum of the filled list; average must truncate towards zero.
      queue_request(REQ_SUM, 0, '0);
      queue_request(REQ_AVERAGE, 0, '0);
      queue_request(REQ_MAX, 0, '0);
      queue_request(REQ_MIN, 0, '0);
      // Search hit in the middle (swaps with its neighbour), hit at the head, and a miss.
      queue_request(REQ_SEARCH, 0, ELEM_NEG1);
      queue_request(REQ_SEARCH, 0, 32'd5);
      queue_request(REQ_SEARCH, 0, 32'd12345);
      queue_request(REQ_SET, 2, 32'hAAAA_AAAA);
      queue_request(REQ_DELETE, 0, '0);
      queue_request(REQ_DELETE, 4, '0);
      queue_request(REQ_UNUSED_HI, 127, ELEM_NEG1);
      queue_request(REQ_UNUSED_LO, 0, '0);
      wait_all_answered();

      // Capacity lowered below the count: elements stay, only append and insert see a
      // full list, and a bad insert index still wins over fullness.
      write_capacity(7'd1);
      queue_request(REQ_APPEND, 0, 32'd9);
      queue_request(REQ_INSERT, 99, 32'd9);
      queue_request(REQ_INSERT, 0, 32'd9);
      queue_request(REQ_GET, 0, '0);
      queue_request(REQ_DELETE, 0, '0);
      wait_all_answered();
      write_capacity(7'd0);
      queue_request(REQ_APPEND, 0, 32'd11);
      queue_request(REQ_SUM, 0, '0);
      wait_all_answered();
      write_capacity(7'd127);
      queue_request(REQ_APPEND, 0, 32'd13);
      queue_request(REQ_AVERAGE, 0, '0);
      wait_all_answered();

      // Random phases. Each alternates stretches that favour growing the list with ones
      // that favour shrinking it, so full and empty lists both come round often. Close to
      // half the values are drawn from a small pool so that searches hit; the rest are
      // extremes and fully random words.
      for (phase = 0; phase < PHASES; phase++) begin
         pacing_off = (phase % 3 == 2);
         write_capacity(cap_plan[phase]);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            filling = ((k / 50) % 2 == 0);
            r = $urandom_range(0, 99);
            if (r < 2) code = OP_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            else if (r < (filling ? 37 : 10)) code = REQ_APPEND;
            else if (r < (filling ? 52 : 16)) code = REQ_INSERT;
            else if (r < (filling ? 59 : 46)) code = REQ_DELETE;
            else if (r < 69) code = REQ_SEARCH;
            else if (r < 77) code = REQ_GET;
            else if (r < 85) code = REQ_SET;
            else if (r < 89) code = REQ_MAX;
            else if (r < 93) code = REQ_MIN;
            else if (r < 96) code = REQ_SUM;
            else code = REQ_AVERAGE;

            r = $urandom_range(0, 99);
            if (r < 40) pos = IDX_W'($urandom_range(0, 7));
            else if (r < 85) pos = IDX_W'($urandom_range(0, 63));
            else pos = IDX_W'($urandom_range(0, 127));

            r = $urandom_range(0, 99);
            if (r < 45) item = $urandom_range(0, 8) - 4;
            else if (r < 52) begin
               case ($urandom_range(0, 2))
                  0: item = ELEM_MAX;
                  1: item = ELEM_MIN;
                  default: item = ELEM_NEG1;
               endcase
            end else item = $urandom;

            queue_request(code, pos, item);
         end
         // The sender waits for every outstanding response before the next setting.
         wait_all_answered();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && answers_due == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
